>>> src/stc_pkg.sv
package stc_pkg;

  // type codes
  localparam logic [3:0] TYPE_BOOL = 4'd0;
  localparam logic [3:0] TYPE_I8   = 4'd1;
  localparam logic [3:0] TYPE_I16  = 4'd2;
  localparam logic [3:0] TYPE_I32  = 4'd3;
  localparam logic [3:0] TYPE_I64  = 4'd4;
  localparam logic [3:0] TYPE_U8   = 4'd5;
  localparam logic [3:0] TYPE_U16  = 4'd6;
  localparam logic [3:0] TYPE_U32  = 4'd7;
  localparam logic [3:0] TYPE_U64  = 4'd8;
  localparam logic [3:0] TYPE_F32  = 4'd9;
  localparam logic [3:0] TYPE_F64  = 4'd10;
  localparam logic [3:0] TYPE_LAST = TYPE_F64;

  // 1e-9 as binary64 magnitude bits
  localparam logic [62:0] BOOL_EPS_MAG = 63'h3E112E0BE826D695;
  localparam logic [31:0] F32_MAX_MAG  = 32'h7F7FFFFF;

  // decode stage to align stage
  typedef struct packed {
    logic        unknown;
    logic        same;
    logic [3:0]  st;
    logic [3:0]  dt;
    logic [63:0] val;
    logic [63:0] dbits;
    logic        neg;
    logic [63:0] mag;
  } s1_t;

  // align stage to round stage
  typedef struct packed {
    logic        unknown;
    logic        same;
    logic [3:0]  st;
    logic [3:0]  dt;
    logic [63:0] val;
    logic [63:0] dbits;
    logic        nan;
    logic        fbool;
    logic        cneg;
    logic [63:0] cmag;
    logic [63:0] norm;
    logic [5:0]  pos;
    logic        n_done;
    logic [31:0] n_word;
    logic [23:0] n_q;
    logic        n_grd;
    logic        n_stk;
    logic [11:0] n_fe;
    logic        n_normal;
  } s2_t;

  // position of the highest set bit, zero for zero
  function automatic logic [5:0] top_bit64(input logic [63:0] x);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

>>> src/stc_decode.sv
module stc_decode
  import stc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] source_bits_i,
  input  logic [3:0]  source_type_i,
  input  logic [3:0]  action_i,
  output logic        valid_o,
  output s1_t         s1_o
);

  logic        valid_q;
  s1_t         s1_d, s1_q;
  logic [63:0] mask;
  logic [63:0] val;
  logic        sbit;
  logic [63:0] f64w;
  logic [7:0]  fx;
  logic [22:0] ffr;
  logic [5:0]  fp;
  logic [63:0] fsh;

  // width mask and sign bit per source type
  always_comb begin
    case (source_type_i)
      TYPE_BOOL:                  mask = 64'h1;
      TYPE_I8, TYPE_U8:           mask = 64'hFF;
      TYPE_I16, TYPE_U16:         mask = 64'hFFFF;
      TYPE_I32, TYPE_U32, TYPE_F32: mask = 64'hFFFF_FFFF;
      default:                    mask = '1;
    endcase
  end

  assign val = source_bits_i & mask;

  always_comb begin
    case (source_type_i)
      TYPE_I8:  sbit = val[7];
      TYPE_I16: sbit = val[15];
      TYPE_I32: sbit = val[31];
      TYPE_I64: sbit = val[63];
      default:  sbit = 1'b0;
    endcase
  end

  // binary32 widened to binary64
  assign fx  = val[30:23];
  assign ffr = val[22:0];
  assign fp  = top_bit64({41'b0, ffr});
  assign fsh = {41'b0, ffr} << (6'd52 - fp);

  always_comb begin
    f64w = {val[31], 63'b0};
    if (fx == 8'hFF) begin
      f64w[62:52] = 11'h7FF;
      if (ffr != 23'b0) f64w[51:0] = {ffr, 29'b0} | {1'b1, 51'b0};
    end else if (fx == 8'h00) begin
      if (ffr != 23'b0) begin
        f64w[62:52] = 11'(fp) + 11'd874;
        f64w[51:0]  = fsh[51:0];
      end
    end else begin
      f64w[62:52] = 11'(fx) + 11'd896;
      f64w[51:0]  = {ffr, 29'b0};
    end
  end

  always_comb begin
    s1_d.unknown = (source_type_i > TYPE_LAST) || (action_i > TYPE_LAST);
    s1_d.same    = (source_type_i == action_i);
    s1_d.st      = source_type_i;
    s1_d.dt      = action_i;
    s1_d.val     = val;
    s1_d.dbits   = (source_type_i == TYPE_F32) ? f64w : val;
    s1_d.neg     = sbit;
    s1_d.mag     = sbit ? ((~val + 64'd1) & mask) : val;
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s1_q <= s1_d;
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

>>> src/stc_align.sv
module stc_align
  import stc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  s1_t  s1_i,
  output logic valid_o,
  output s2_t  s2_o
);

  logic         valid_q;
  s2_t          s2_d, s2_q;
  logic         sgn;
  logic [10:0]  ex;
  logic [51:0]  fr;
  logic [52:0]  m;
  logic         is_nan;
  logic [116:0] ish;
  logic [63:0]  fmag;
  logic         is_flt;
  logic [5:0]   ipos;
  logic [5:0]   nsh;
  logic [116:0] rsh;

  assign sgn    = s1_i.dbits[63];
  assign ex     = s1_i.dbits[62:52];
  assign fr     = s1_i.dbits[51:0];
  assign m      = {ex != 11'd0, fr};
  assign is_nan = (ex == 11'h7FF) && (fr != 52'b0);
  assign is_flt = (s1_i.st == TYPE_F32) || (s1_i.st == TYPE_F64);

  // float to integer: truncate and saturate
  assign ish = {64'b0, m} << 6'(ex - 11'd1023);

  always_comb begin
    if (!sgn && ex >= 11'd1087) fmag = '1;
    else if (sgn && ex >= 11'd1086) fmag = 64'h8000_0000_0000_0000;
    else if (ex < 11'd1023) fmag = 64'd0;
    else fmag = ish[115:52];
  end

  // integer normalize for float destinations
  assign ipos = top_bit64(s1_i.mag);

  // binary64 to binary32 alignment
  assign nsh = (ex >= 11'd897) ? 6'd29 : 6'(11'd926 - ex);
  assign rsh = {m, 64'b0} >> nsh;

  always_comb begin
    s2_d.unknown = s1_i.unknown;
    s2_d.same    = s1_i.same;
    s2_d.st      = s1_i.st;
    s2_d.dt      = s1_i.dt;
    s2_d.val     = s1_i.val;
    s2_d.dbits   = s1_i.dbits;
    s2_d.nan     = is_nan;
    s2_d.fbool   = (s1_i.dbits[62:0] >= BOOL_EPS_MAG) && !is_nan;
    s2_d.cneg    = is_flt ? sgn : s1_i.neg;
    s2_d.cmag    = is_flt ? fmag : s1_i.mag;
    s2_d.norm    = s1_i.mag << (6'd63 - ipos);
    s2_d.pos     = ipos;
    s2_d.n_q     = rsh[87:64];
    s2_d.n_grd   = rsh[63];
    s2_d.n_stk   = |rsh[62:0];
    s2_d.n_fe    = 12'(ex) - 12'd896;
    s2_d.n_normal = (ex >= 11'd897);
    s2_d.n_done  = 1'b1;
    s2_d.n_word  = {sgn, 31'b0};
    if (ex == 11'h7FF) begin
      s2_d.n_word = is_nan ? ({sgn, 31'b0} | 32'h7FC0_0000 | {9'b0, fr[51:29]})
                           : ({sgn, 31'b0} | F32_MAX_MAG);
    end else if (ex == 11'd0 || ex < 11'd871) begin
      s2_d.n_word = {sgn, 31'b0};
    end else begin
      s2_d.n_done = 1'b0;
    end
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s2_q <= s2_d;
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

>>> src/stc_round.sv
module stc_round
  import stc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  s2_t         s2_i,
  output logic        valid_o,
  output logic [63:0] result_o
);

  logic        valid_q;
  logic [63:0] res_d, res_q;
  logic [53:0] q64;
  logic [24:0] q32;
  logic [63:0] i2f64;
  logic [63:0] i2f32;
  logic [24:0] nq;
  logic [11:0] nfe;
  logic [31:0] n32;
  logic [63:0] clamp;
  logic [63:0] lim;
  logic [63:0] wmask;
  logic        is_sgn;

  // integer to float, round to nearest even
  assign q64 = {1'b0, s2_i.norm[63:11]}
             + 54'(s2_i.norm[10] && ((|s2_i.norm[9:0]) || s2_i.norm[11]));
  assign q32 = {1'b0, s2_i.norm[63:40]}
             + 25'(s2_i.norm[39] && ((|s2_i.norm[38:0]) || s2_i.norm[40]));

  always_comb begin
    i2f64 = 64'd0;
    i2f32 = 64'd0;
    if (s2_i.cmag != 64'd0) begin
      i2f64 = {s2_i.cneg, 11'(s2_i.pos) + 11'd1023 + 11'(q64[53]), q64[51:0]};
      i2f32 = {32'b0, s2_i.cneg, 8'(s2_i.pos) + 8'd127 + 8'(q32[24]), q32[22:0]};
    end
  end

  // binary64 to binary32 rounding
  assign nq = {1'b0, s2_i.n_q} + 25'(s2_i.n_grd && (s2_i.n_stk || s2_i.n_q[0]));

  always_comb begin
    nfe = s2_i.n_fe + 12'(nq[24]);
    if (s2_i.n_done) begin
      n32 = s2_i.n_word;
    end else if (s2_i.n_normal) begin
      if (nfe >= 12'd255) n32 = {s2_i.dbits[63], 31'b0} | F32_MAX_MAG;
      else n32 = {s2_i.dbits[63], nfe[7:0], nq[24] ? nq[23:1] : nq[22:0]};
    end else begin
      n32 = {s2_i.dbits[63], 31'b0} | {8'b0, nq[23:0]};
    end
  end

  // integer clamp to destination range
  always_comb begin
    is_sgn = 1'b0;
    case (s2_i.dt)
      TYPE_I8:  begin is_sgn = 1'b1; wmask = 64'hFF; end
      TYPE_I16: begin is_sgn = 1'b1; wmask = 64'hFFFF; end
      TYPE_I32: begin is_sgn = 1'b1; wmask = 64'hFFFF_FFFF; end
      TYPE_I64: begin is_sgn = 1'b1; wmask = '1; end
      TYPE_U8:  wmask = 64'hFF;
      TYPE_U16: wmask = 64'hFFFF;
      TYPE_U32: wmask = 64'hFFFF_FFFF;
      default:  wmask = '1;
    endcase
    lim = (wmask >> 1) + 64'd1;
    if (is_sgn) begin
      if (s2_i.cneg) clamp = (~((s2_i.cmag > lim) ? lim : s2_i.cmag) + 64'd1) & wmask;
      else clamp = (s2_i.cmag > lim - 64'd1) ? lim - 64'd1 : s2_i.cmag;
    end else begin
      if (s2_i.cneg) clamp = 64'd0;
      else clamp = (s2_i.cmag > wmask) ? wmask : s2_i.cmag;
    end
  end

  // final selection
  always_comb begin
    if (s2_i.unknown) res_d = 64'd0;
    else if (s2_i.same) res_d = s2_i.val;
    else if (s2_i.st == TYPE_F32 || s2_i.st == TYPE_F64) begin
      if (s2_i.dt == TYPE_F64) res_d = s2_i.dbits;
      else if (s2_i.dt == TYPE_F32) res_d = {32'b0, n32};
      else if (s2_i.dt == TYPE_BOOL) res_d = {63'b0, s2_i.fbool};
      else if (s2_i.nan) res_d = 64'd0;
      else res_d = clamp;
    end else begin
      if (s2_i.dt == TYPE_BOOL) res_d = {63'b0, s2_i.cmag != 64'd0};
      else if (s2_i.dt == TYPE_F32) res_d = i2f32;
      else if (s2_i.dt == TYPE_F64) res_d = i2f64;
      else res_d = clamp;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

>>> src/saturating_type_converter.sv
// saturating type converter
// input channel: in_valid_i / in_ready_o with source_bits_i, source_type_i
// (source type code) and action_i (destination type code).
// output channel: out_valid_o / out_ready_i with result_bits_o, the raw
// destination bits zero-extended to 64 bits.
// three register stages: decode and binary32 widening, alignment shifts and
// leading-one search, then rounding, clamping and result select.
// out_valid_o rises once an item has passed the decode, align and round
// registers; one item is taken per cycle when the receiver keeps ready high.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated, and ready returns in the
// cycle the receiver takes the result.
// reset clears all stage valid bits; the stage data registers are not reset.
module saturating_type_converter
  import stc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] source_bits_i,
  input  logic [3:0]  source_type_i,
  input  logic [3:0]  action_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_bits_o
);

  logic en;
  logic v1, v2;
  s1_t  s1;
  s2_t  s2;

  // pipeline advances unless a result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  stc_decode u_decode (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .source_bits_i, .source_type_i, .action_i,
    .valid_o(v1), .s1_o(s1)
  );

  stc_align u_align (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .s1_i(s1),
    .valid_o(v2), .s2_o(s2)
  );

  stc_round u_round (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .s2_i(s2),
    .valid_o(out_valid_o), .result_o(result_bits_o)
  );

endmodule

>>> src/stc_checker.sv
module stc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] result_bits_o
);

  // held result stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped during stall");

  // held result keeps its bits
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_bits_o))
    else $error("result changed during stall");

  // input side stalls only behind a waiting result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output side");

  // a valid result never carries unknown bits
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(result_bits_o))
    else $error("valid result with unknown bits");

  // offered input transfer stays offered until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input transfer withdrawn");

endmodule

bind saturating_type_converter stc_checker u_stc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .result_bits_o
);

>>> tb/saturating_type_converter_test.sv
`timescale 1ns / 100ps

module saturating_type_converter_test;
  import stc_pkg::*;

  typedef struct {
    logic [63:0] bits;
    logic [3:0]  st;
    logic [3:0]  dt;
  } conv_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] source_bits_i = '0;
  logic [3:0]  source_type_i = '0;
  logic [3:0]  action_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_bits_o;

  conv_item_t  pending_items[$];
  logic [63:0] expected_results[$];
  int          items_sent = 0;
  int          mismatches = 0;
  int          failures = 0;
  bit          in_fire = 0;
  int          hold_cycles = 0;
  bit          hold_done = 0;

  saturating_type_converter DUT (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------- conversion predictor ----------------
  function automatic int unsigned width_of(logic [3:0] t);
    if (t == TYPE_BOOL) return 1;
    if (t == TYPE_F32) return 32;
    if (t == TYPE_F64) return 64;
    return 8 << ((t - 1) & 3);
  endfunction

  function automatic logic [63:0] mask_of(int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic int unsigned msb_pos(logic [63:0] x);
    int unsigned p;
    p = 0;
    for (int i = 0; i < 64; i++) if (x[i]) p = i;
    return p;
  endfunction

  // shift right rounding to nearest even, sh in 1..63
  function automatic logic [63:0] shift_rne(logic [63:0] m, int unsigned sh);
    logic [63:0] q, rem, half;
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  function automatic logic [63:0] int_to_float(bit neg, logic [63:0] mag,
                                               int unsigned mbits, int unsigned bias,
                                               int unsigned signpos);
    int unsigned p, e;
    logic [63:0] frac;
    if (mag == 0) return '0;
    p = msb_pos(mag);
    e = p;
    if (p <= mbits) frac = mag << (mbits - p);
    else begin
      frac = shift_rne(mag, p - mbits);
      if ((frac >> (mbits + 1)) != 0) begin
        frac >>= 1;
        e++;
      end
    end
    return (neg ? (64'd1 << signpos) : 64'd0) | (64'(e + bias) << mbits)
           | (frac & mask_of(mbits));
  endfunction

  function automatic logic [63:0] widen_single(logic [31:0] x);
    logic [63:0] res, fr;
    int unsigned p;
    res = 64'(x[31]) << 63;
    fr = 64'(x[22:0]);
    if (x[30:23] == 8'hFF) begin
      res |= 64'h7FF << 52;
      if (fr != 0) res |= (64'd1 << 51) | (fr << 29);
      return res;
    end
    if (x[30:23] == 8'h00) begin
      if (fr == 0) return res;
      p = msb_pos(fr);
      return res | (64'(p + 874) << 52) | ((fr << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF);
    end
    return res | (64'(x[30:23] + 896) << 52) | (fr << 29);
  endfunction

  function automatic logic [63:0] narrow_double(logic [63:0] x);
    logic [63:0] sb, fr, m, q;
    int ex, fe, sh;
    sb = 64'(x[63]) << 31;
    ex = int'(x[62:52]);
    fr = x & 64'h000F_FFFF_FFFF_FFFF;
    if (ex == 2047) begin
      if (fr != 0) return sb | 64'h7FC0_0000 | (fr >> 29);
      return sb | 64'(F32_MAX_MAG);
    end
    if (ex == 0) return sb;
    m = fr | (64'd1 << 52);
    fe = ex - 896;
    if (fe >= 1) begin
      q = shift_rne(m, 29);
      if ((q >> 24) != 0) begin
        q >>= 1;
        fe++;
      end
      if (fe >= 255) return sb | 64'(F32_MAX_MAG);
      return sb | (64'(fe) << 23) | (q & 64'h7F_FFFF);
    end
    sh = 30 - fe;
    if (sh > 55) return sb;
    return sb | shift_rne(m, sh);
  endfunction

  function automatic logic [63:0] clamp_to_int(bit neg, logic [63:0] mag, logic [3:0] dt);
    int unsigned dw;
    logic [63:0] lim;
    dw = width_of(dt);
    if (dt <= TYPE_I64) begin
      if (neg) begin
        lim = 64'd1 << (dw - 1);
        if (mag > lim) mag = lim;
        return (64'd0 - mag) & mask_of(dw);
      end
      lim = (64'd1 << (dw - 1)) - 64'd1;
      return (mag > lim) ? lim : mag;
    end
    if (neg) return '0;
    return (mag > mask_of(dw)) ? mask_of(dw) : mag;
  endfunction

  function automatic logic [63:0] convert_value(logic [63:0] bits, logic [3:0] st,
                                                logic [3:0] dt);
    logic [63:0] val, dbits, mag, m;
    int unsigned sw;
    int u;
    bit neg;
    neg = 0;
    mag = '0;
    if (st > TYPE_LAST || dt > TYPE_LAST) return '0;
    sw = width_of(st);
    val = bits & mask_of(sw);
    if (st == dt) return val;
    if (st >= TYPE_F32) begin
      dbits = (st == TYPE_F32) ? widen_single(val[31:0]) : val;
      if (dt == TYPE_F64) return dbits;
      if (dt == TYPE_F32) return narrow_double(val);
      // nan compares false everywhere
      if (dbits[62:52] == 11'h7FF && dbits[51:0] != 0) return '0;
      if (dt == TYPE_BOOL) return (dbits[62:0] >= BOOL_EPS_MAG) ? 64'd1 : 64'd0;
      u = int'(dbits[62:52]) - 1023;
      if (!dbits[63] && u >= 64) mag = '1;
      else if (dbits[63] && u >= 63) begin
        neg = 1;
        mag = 64'd1 << 63;
      end else begin
        neg = dbits[63] && (dbits[62:0] != 0);
        m = {11'd0, 1'b1, dbits[51:0]};
        if (u < 0) mag = '0;
        else if (u >= 52) mag = m << (u - 52);
        else mag = m >> (52 - u);
      end
    end else begin
      if (st >= TYPE_I8 && st <= TYPE_I64 && val[sw-1]) begin
        neg = 1;
        mag = (64'd0 - val) & mask_of(sw);
      end else mag = val;
    end
    if (dt == TYPE_BOOL) return (mag != 0) ? 64'd1 : 64'd0;
    if (dt == TYPE_F32) return int_to_float(neg, mag, 23, 127, 31);
    if (dt == TYPE_F64) return int_to_float(neg, mag, 52, 1023, 63);
    return clamp_to_int(neg, mag, dt);
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic [3:0] pick_type();
    if ($urandom_range(0, 19) == 0) return 4'($urandom_range(11, 15));
    return 4'($urandom_range(0, 10));
  endfunction

  function automatic logic [63:0] pick_bits(logic [3:0] st);
    logic [63:0] r;
    logic [10:0] e;
    logic [7:0]  e8;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return r;
      1: return r & 64'h3;
      2: return r ^ {$urandom_range(0, 1) ? 1'b1 : 1'b0, 63'd0};
      default: ;
    endcase
    if (st == TYPE_F32) begin
      case ($urandom_range(0, 4))
        0: e8 = 8'($urandom_range(97, 200));
        1: e8 = 8'd0;
        2: e8 = 8'hFF;
        default: e8 = 8'($urandom_range(120, 192));
      endcase
      if ($urandom_range(0, 2) == 0) r[22:0] = r[22:0] & 23'h7;
      r[30:23] = e8;
      return r;
    end
    case ($urandom_range(0, 6))
      0: e = 11'($urandom);
      1: e = 11'd0;
      2: e = 11'h7FF;
      3: e = 11'($urandom_range(840, 930));
      4: e = 11'($urandom_range(1240, 1300));
      5: e = 11'($urandom_range(990, 1010));
      default: e = 11'($urandom_range(1018, 1090));
    endcase
    if ($urandom_range(0, 2) == 0) r[51:0] = r[51:0] & 52'hF;
    if ($urandom_range(0, 4) == 0) r[51:0] = r[51:0] | 52'hF_FFFF_E000_0000;
    r[62:52] = e;
    return r;
  endfunction

  task automatic add_item(logic [63:0] bits, logic [3:0] st, logic [3:0] dt);
    conv_item_t it;
    it.bits = bits;
    it.st = st;
    it.dt = dt;
    pending_items.push_back(it);
  endtask

  initial begin
    logic [3:0] st;
    // directed: extremes, every destination type except U16, special cases
    add_item(64'h0000_0000_0000_0080, TYPE_I8, TYPE_U8);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, TYPE_U64, TYPE_I64);
    add_item(64'h8000_0000_0000_0000, TYPE_I64, TYPE_I8);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, TYPE_U64, TYPE_F32);
    add_item(64'h8000_0000_0000_0001, TYPE_I64, TYPE_F64);
    add_item(64'hFFFF_FFFF_FFFF_FFFE, TYPE_BOOL, TYPE_I16);
    add_item(64'h7FF8_0000_0000_0001, TYPE_F64, TYPE_F64);
    add_item(64'h1234, 4'd11, TYPE_U8);
    add_item(64'h1234, TYPE_U16, 4'd15);
    add_item(64'h7FF8_0000_0000_0000, TYPE_F64, TYPE_BOOL);
    add_item(64'(BOOL_EPS_MAG), TYPE_F64, TYPE_BOOL);
    add_item(64'(BOOL_EPS_MAG) - 64'd1 | 64'h8000_0000_0000_0000, TYPE_F64, TYPE_BOOL);
    add_item(64'h7FC0_0001, TYPE_F32, TYPE_I32);
    add_item(64'hFFF0_0000_0000_0000, TYPE_F64, TYPE_I32);
    add_item(64'h7F80_0000, TYPE_F32, TYPE_U64);
    add_item(64'h7FF0_0000_0000_0000, TYPE_F64, TYPE_F32);
    add_item(64'h47F0_0000_0000_0000, TYPE_F64, TYPE_F32);
    add_item(64'hFFF4_0000_2000_0000, TYPE_F64, TYPE_F32);
    add_item(64'hFF80_1234, TYPE_F32, TYPE_F64);
    add_item(64'h3690_0000_0000_0001, TYPE_F64, TYPE_F32);
    add_item(64'h8000_0000_0000_0001, TYPE_F64, TYPE_F32);
    add_item(64'h0000_0001, TYPE_F32, TYPE_F64);
    add_item(64'h43F0_0000_0000_0000, TYPE_F64, TYPE_U64);
    add_item(64'hC3E0_0000_0000_0000, TYPE_F64, TYPE_I64);
    add_item(64'hBFEF_FFFF_FFFF_FFFF, TYPE_F64, TYPE_U32);
    // random
    repeat (1350) begin
      st = pick_type();
      add_item(pick_bits(st), st, pick_type());
    end
  end

  // ---------------- driver ----------------
  always @(negedge clk_i) begin
    int phase;
    conv_item_t it;
    phase = (items_sent < 450) ? 0 : (items_sent < 900) ? 1 : 2;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_items.size() > 0 &&
          $urandom_range(0, 99) >= ((phase == 0) ? 6 : (phase == 1) ? 57 : 0)) begin
        it = pending_items.pop_front();
        source_bits_i <= it.bits;
        source_type_i <= it.st;
        action_i <= it.dt;
        in_valid_i <= 1'b1;
        items_sent++;
      end else in_valid_i <= 1'b0;
    end
  end

  // receiver ready, with one long hold-off to back up the pipeline
  always @(negedge clk_i) begin
    int phase;
    phase = (items_sent < 450) ? 0 : (items_sent < 900) ? 1 : 2;
    if (!hold_done && items_sent >= 1100) begin
      hold_done = 1;
      hold_cycles = 300;
    end
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else
      out_ready_i <= $urandom_range(0, 99) >= ((phase == 0) ? 57 : (phase == 1) ? 6 : 0);
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    logic [63:0] want;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        failures++;
        $display("unexpected result transfer: %h", result_bits_o);
      end else begin
        want = expected_results.pop_front();
        if (result_bits_o !== want) begin
          mismatches++;
          failures++;
          if (mismatches <= 10)
            $display("result_bits mismatch: expected %h actual %h", want, result_bits_o);
        end
      end
    end
    if (in_fire)
      expected_results.push_back(convert_value(source_bits_i, source_type_i, action_i));
  end

  // ---------------- sequence and end of run ----------------
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    #80;
    wait (pending_items.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) failures++;
    if (failures == 0) $display("[saturating_type_converter] OK");
    else $display("[saturating_type_converter] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[saturating_type_converter] ERROR");
    $finish;
  end

endmodule

>>> saturating_type_converter.f
src/stc_pkg.sv
src/stc_decode.sv
src/stc_align.sv
src/stc_round.sv
src/saturating_type_converter.sv
src/stc_checker.sv
tb/saturating_type_converter_test.sv
